>>> hw/rtl/sacl_pkg.sv
// Shared types and constants for the set-associative LRU cache simulation unit.
// No dependencies; every other file of the block but sacl_ram imports this package.
package sacl_pkg;

  // Build-time geometry
  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int NUM_SETS     = 1 << MAX_SET_BITS;
  localparam int SET_W        = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int RANK_W       = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAY_IDX_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAYCNT_W     = $clog2(MAX_WAYS + 1);

  localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

  // Field widths
  localparam int ADDR_W = 32;
  localparam int TAG_W  = 32;
  localparam int CNT_W  = 32;
  localparam int CMD_W  = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

  localparam logic [2:0] SET_BITS_RST   = 3'd4;
  localparam logic [4:0] BLOCK_BITS_RST = 5'd4;
  localparam logic [3:0] WAYS_RST       = 4'd1;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD   = 2'd0,
    CMD_STORE  = 2'd1,
    CMD_MODIFY = 2'd2,
    CMD_IFETCH = 2'd3
  } cmd_e;

  // One way of a set row as kept in the row memory
  typedef struct packed {
    logic              valid;
    logic [RANK_W-1:0] rank;
    logic [TAG_W-1:0]  tag;
  } way_t;

  typedef way_t [MAX_WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  // Outcome of one lookup
  typedef struct packed {
    logic hit;
    logic evict;
  } lookup_res_t;

endpackage

>>> hw/rtl/sacl_chan_if.sv
// Valid/ready channel interfaces for the cache simulation unit: trace access
// requests and per-access results. Depends on sacl_pkg.
interface sacl_req_if import sacl_pkg::*;;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output command, output address, input ready);
  modport sink   (input valid, input command, input address, output ready);
endinterface

interface sacl_rsp_if import sacl_pkg::*;;
  logic             valid;
  logic             ready;
  logic             first_hit;
  logic             evicted;
  logic             was_ignored;
  logic [CNT_W-1:0] total_hits;
  logic [CNT_W-1:0] total_misses;
  logic [CNT_W-1:0] total_evictions;

  modport source (output valid, output first_hit, output evicted, output was_ignored,
                  output total_hits, output total_misses, output total_evictions,
                  input ready);
  modport sink   (input valid, input first_hit, input evicted, input was_ignored,
                  input total_hits, input total_misses, input total_evictions,
                  output ready);
endinterface

>>> hw/rtl/sacl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/sacl_lookup.sv
// Tag compare, LRU rank update and victim selection over one set row.
// Depends on sacl_pkg.
module sacl_lookup import sacl_pkg::*; (
  input  row_t                row_i,
  input  logic [TAG_W-1:0]    tag_i,
  input  logic [WAYCNT_W-1:0] ways_i,
  output row_t                row_o,
  output lookup_res_t         res_o
);

  logic [MAX_WAYS-1:0]  in_use;
  logic [MAX_WAYS-1:0]  match;
  logic [MAX_WAYS-1:0]  empty;
  logic                 hit_found;
  logic                 fill_found;
  logic [WAY_IDX_W-1:0] hit_way;
  logic [WAY_IDX_W-1:0] fill_way;
  logic [WAY_IDX_W-1:0] vic_way;
  logic [RANK_W-1:0]    vic_rank;
  logic [RANK_W-1:0]    hit_rank;
  logic [WAY_IDX_W-1:0] sel_way;

  // Per-way compare
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w] = (WAYCNT_W'(w) < ways_i);
      match[w]  = in_use[w] && row_i[w].valid && (row_i[w].tag == tag_i);
      empty[w]  = in_use[w] && !row_i[w].valid;
    end
  end

  // Lowest matching way, lowest empty way, lowest way with the largest rank
  always_comb begin
    hit_found  = 1'b0;
    fill_found = 1'b0;
    hit_way    = '0;
    fill_way   = '0;
    hit_rank   = '0;
    vic_way    = '0;
    vic_rank   = row_i[0].rank;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (match[w] && !hit_found) begin
        hit_found = 1'b1;
        hit_way   = WAY_IDX_W'(w);
        hit_rank  = row_i[w].rank;
      end
      if (empty[w] && !fill_found) begin
        fill_found = 1'b1;
        fill_way   = WAY_IDX_W'(w);
      end
      if (w > 0 && in_use[w] && (row_i[w].rank > vic_rank)) begin
        vic_way  = WAY_IDX_W'(w);
        vic_rank = row_i[w].rank;
      end
    end
  end

  assign sel_way = hit_found ? hit_way : (fill_found ? fill_way : vic_way);

  // Age valid ways (on a hit only younger ones); selected way becomes newest
  always_comb begin
    row_o = row_i;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && (WAY_IDX_W'(w) != sel_way) && row_i[w].valid &&
          (row_i[w].rank < RANK_MAX) && (!hit_found || (row_i[w].rank < hit_rank))) begin
        row_o[w].rank = row_i[w].rank + RANK_W'(1);
      end
    end
    row_o[sel_way].rank = '0;
    if (!hit_found) begin
      row_o[sel_way].valid = 1'b1;
      row_o[sel_way].tag   = tag_i;
    end
  end

  assign res_o.hit   = hit_found;
  assign res_o.evict = !hit_found && !fill_found;

endmodule

>>> hw/rtl/set_assoc_lru_cache_sim_unit.sv
// Top level of the set-associative LRU cache simulation unit.
// Depends on sacl_pkg, sacl_chan_if, sacl_ram and sacl_lookup.
//
// Usage:
//   req_i carries one trace access per transfer (command, address); rsp_o
//   returns one result per access with the hit/evict/ignored flags and the
//   running hit, miss and eviction counts. The cfg port writes set_bits
//   (index 0), block_bits (1) and ways_in_use (2); other indexes are
//   dropped. Write it only while the block is idle.
//   The transfer cycle of an access issues the read of the set row from
//   the row RAM; the update state that follows compares tags, updates
//   ranks, writes the row back and loads the result register. A new access
//   is taken only once the update of the previous one is done, with the
//   read-modify-write on the single row RAM port pair. A modify does one
//   row update; its store always hits and only bumps the hit count.
//   A finished result waits in the output register; the next access is
//   still taken, but its update stalls while the previous result has not
//   been transferred.
//   Reset clears per-row init flags (all lines read as invalid, rank zero),
//   counters, state, config and result valid; no clearing pass is needed.
module set_assoc_lru_cache_sim_unit import sacl_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  sacl_req_if.sink              req_i,
  sacl_rsp_if.source            rsp_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam logic ST_IDLE   = 1'b0;
  localparam logic ST_LOOKUP = 1'b1;

  // Configuration registers
  logic [2:0] set_bits_q;
  logic [4:0] block_bits_q;
  logic [3:0] ways_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_bits_q   <= SET_BITS_RST;
      block_bits_q <= BLOCK_BITS_RST;
      ways_q       <= WAYS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SET_BITS:   set_bits_q   <= cfg_wdata_i[2:0];
        CFG_BLOCK_BITS: block_bits_q <= cfg_wdata_i[4:0];
        CFG_WAYS:       ways_q       <= cfg_wdata_i[3:0];
        default:        ;
      endcase
    end
  end

  // Effective geometry
  logic [2:0]          sb_eff;
  logic [WAYCNT_W-1:0] ways_eff;
  logic [5:0]          tag_shift;
  logic [SET_W:0]      set_mask;
  logic [ADDR_W-1:0]   addr_shr;
  logic [SET_W-1:0]    set_idx;
  logic [TAG_W-1:0]    tag_d;

  assign sb_eff = (32'(set_bits_q) > MAX_SET_BITS) ? 3'(MAX_SET_BITS) : set_bits_q;

  always_comb begin
    if (ways_q == 4'd0) begin
      ways_eff = WAYCNT_W'(1);
    end else if (32'(ways_q) > MAX_WAYS) begin
      ways_eff = WAYCNT_W'(MAX_WAYS);
    end else begin
      ways_eff = WAYCNT_W'(ways_q);
    end
  end

  // Set index and tag of the incoming address
  assign set_mask  = ((SET_W+1)'(1) << sb_eff) - (SET_W+1)'(1);
  assign addr_shr  = req_i.address >> block_bits_q;
  assign set_idx   = addr_shr[SET_W-1:0] & set_mask[SET_W-1:0];
  assign tag_shift = {3'b000, sb_eff} + {1'b0, block_bits_q};
  assign tag_d     = tag_shift[5] ? '0 : (req_i.address >> tag_shift[4:0]);

  // Control
  logic             state_q;
  logic             state_d;
  logic             in_xfer;
  logic             done;
  logic             rsp_valid_q;
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  cmd_e             cmd_q;
  logic             row_init_sel_q;
  logic [NUM_SETS-1:0] row_init_q;

  assign req_i.ready = (state_q == ST_IDLE);
  assign in_xfer     = req_i.valid && req_i.ready;
  assign done        = (state_q == ST_LOOKUP) && (!rsp_valid_q || rsp_o.ready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (in_xfer) state_d = ST_LOOKUP;
      ST_LOOKUP: if (done) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Access held for the update cycle
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      set_q          <= set_idx;
      tag_q          <= tag_d;
      cmd_q          <= cmd_e'(req_i.command);
      row_init_sel_q <= row_init_q[set_idx];
    end
  end

  // Row memory and update
  row_t        row_rd;
  row_t        row_cur;
  row_t        row_new;
  lookup_res_t lk_res;
  logic        do_lookup;
  logic        ram_we;

  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (set_q),
    .wdata_i (row_new),
    .re_i    (in_xfer),
    .raddr_i (set_idx),
    .rdata_o (row_rd)
  );

  // A row never written reads as all invalid with rank zero
  assign row_cur = row_init_sel_q ? row_rd : '0;

  sacl_lookup u_lookup (
    .row_i  (row_cur),
    .tag_i  (tag_q),
    .ways_i (ways_eff),
    .row_o  (row_new),
    .res_o  (lk_res)
  );

  assign do_lookup = (cmd_q != CMD_IFETCH);
  assign ram_we    = done && do_lookup;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_init_q <= '0;
    end else if (ram_we) begin
      row_init_q[set_q] <= 1'b1;
    end
  end

  // Counters and result register
  logic [CNT_W-1:0] hits_q;
  logic [CNT_W-1:0] misses_q;
  logic [CNT_W-1:0] evicts_q;
  logic [CNT_W-1:0] hits_d;
  logic [CNT_W-1:0] misses_d;
  logic [CNT_W-1:0] evicts_d;
  logic             first_hit_q;
  logic             evicted_q;
  logic             ignored_q;

  always_comb begin
    hits_d   = hits_q;
    misses_d = misses_q;
    evicts_d = evicts_q;
    if (do_lookup) begin
      hits_d   = hits_q + CNT_W'(lk_res.hit) + CNT_W'(cmd_q == CMD_MODIFY);
      misses_d = misses_q + CNT_W'(!lk_res.hit);
      evicts_d = evicts_q + CNT_W'(lk_res.evict);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hits_q      <= '0;
      misses_q    <= '0;
      evicts_q    <= '0;
      rsp_valid_q <= 1'b0;
    end else if (done) begin
      hits_q      <= hits_d;
      misses_q    <= misses_d;
      evicts_q    <= evicts_d;
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      first_hit_q <= do_lookup && lk_res.hit;
      evicted_q   <= do_lookup && lk_res.evict;
      ignored_q   <= !do_lookup;
    end
  end

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.first_hit       = first_hit_q;
  assign rsp_o.evicted         = evicted_q;
  assign rsp_o.was_ignored     = ignored_q;
  assign rsp_o.total_hits      = hits_q;
  assign rsp_o.total_misses    = misses_q;
  assign rsp_o.total_evictions = evicts_q;

  // Checks
  a_xfer_to_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_LOOKUP))
    else $error("accepted access did not enter the update cycle");

  a_we_in_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (state_q == ST_LOOKUP) && !in_xfer)
    else $error("row write outside the update cycle");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> !(first_hit_q && evicted_q))
    else $error("result flags both hit and eviction");

  a_ignored_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && ignored_q) |-> (!first_hit_q && !evicted_q))
    else $error("ignored fetch reports a lookup outcome");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_o.ready) |=> rsp_valid_q && $stable(hits_q))
    else $error("stalled result changed");

endmodule

>>> tb/tb_set_assoc_lru_cache_sim_unit.sv
// Self-checking testbench for set_assoc_lru_cache_sim_unit: directed and random
// trace accesses checked against a tag-only LRU cache predictor.
// Depends on sacl_pkg, sacl_chan_if and the RTL of the unit.
module tb_set_assoc_lru_cache_sim_unit import sacl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned ITEMS_PER_PHASE = 90;
  localparam int unsigned NUM_PHASES = 8;
  localparam int unsigned DRAIN_CYCLES = 4;

  // Expected outcome of one access
  typedef struct packed {
    logic             first_hit;
    logic             evicted;
    logic             was_ignored;
    logic [CNT_W-1:0] total_hits;
    logic [CNT_W-1:0] total_misses;
    logic [CNT_W-1:0] total_evictions;
  } access_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  sacl_req_if req_if ();
  sacl_rsp_if rsp_if ();

  set_assoc_lru_cache_sim_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Cache mirror: per-line valid, tag and recency rank, plus geometry and counters
  bit               line_ok   [NUM_SETS][MAX_WAYS];
  logic [TAG_W-1:0] line_tag  [NUM_SETS][MAX_WAYS];
  int unsigned      line_rank [NUM_SETS][MAX_WAYS];
  logic [2:0]       cfg_set_bits;
  logic [4:0]       cfg_block_bits;
  logic [3:0]       cfg_ways;
  logic [CNT_W-1:0] hit_cnt;
  logic [CNT_W-1:0] miss_cnt;
  logic [CNT_W-1:0] evict_cnt;

  access_result_t pending_results[$];
  int unsigned    mismatch_count;
  int unsigned    results_seen;
  int unsigned    quiet_cycles;
  int unsigned    stall_left;
  bit             send_calm;
  bit             recv_calm;

  function automatic int unsigned eff_set_bits();
    return (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : cfg_set_bits;
  endfunction

  function automatic int unsigned eff_ways();
    if (cfg_ways == 0) return 1;
    return (cfg_ways > MAX_WAYS) ? MAX_WAYS : cfg_ways;
  endfunction

  // Age valid in-use ways of a set whose rank is below limit; ranks saturate
  function automatic void age_set(input int unsigned set_idx, input int unsigned ways,
                                  input int unsigned skip, input int unsigned limit);
    for (int unsigned w = 0; w < ways; w++) begin
      if (w != skip && line_ok[set_idx][w] && line_rank[set_idx][w] < limit &&
          line_rank[set_idx][w] < MAX_WAYS - 1)
        line_rank[set_idx][w]++;
    end
  endfunction

  // One lookup with fill or LRU replacement; returns 1 on hit
  function automatic bit probe_cache(input logic [ADDR_W-1:0] addr, output bit evict);
    int unsigned sb;
    int unsigned ways;
    int unsigned shift;
    int unsigned set_idx;
    int unsigned victim;
    logic [TAG_W-1:0] tag;
    evict   = 1'b0;
    sb      = eff_set_bits();
    ways    = eff_ways();
    set_idx = (addr >> cfg_block_bits) & ((32'd1 << sb) - 1);
    shift   = sb + cfg_block_bits;
    tag     = (shift >= ADDR_W) ? '0 : addr >> shift;
    // lowest matching way wins
    for (int unsigned w = 0; w < ways; w++) begin
      if (line_ok[set_idx][w] && line_tag[set_idx][w] == tag) begin
        age_set(set_idx, ways, w, line_rank[set_idx][w]);
        line_rank[set_idx][w] = 0;
        hit_cnt++;
        return 1'b1;
      end
    end
    miss_cnt++;
    for (int unsigned w = 0; w < ways; w++) begin
      if (!line_ok[set_idx][w]) begin
        age_set(set_idx, ways, w, MAX_WAYS);
        line_ok[set_idx][w]   = 1'b1;
        line_tag[set_idx][w]  = tag;
        line_rank[set_idx][w] = 0;
        return 1'b0;
      end
    end
    // victim: lowest way holding the largest rank
    victim = 0;
    for (int unsigned w = 1; w < ways; w++) begin
      if (line_rank[set_idx][w] > line_rank[set_idx][victim]) victim = w;
    end
    age_set(set_idx, ways, victim, MAX_WAYS);
    line_tag[set_idx][victim]  = tag;
    line_rank[set_idx][victim] = 0;
    evict_cnt++;
    evict = 1'b1;
    return 1'b0;
  endfunction

  function automatic access_result_t predict_access(input cmd_e cmd,
                                                    input logic [ADDR_W-1:0] addr);
    access_result_t res;
    bit ev;
    bit store_ev;
    res = '0;
    if (cmd == CMD_IFETCH) begin
      res.was_ignored = 1'b1;
    end else begin
      res.first_hit = probe_cache(addr, ev);
      res.evicted   = ev;
      // modify: the store half follows the load to the same address
      if (cmd == CMD_MODIFY) void'(probe_cache(addr, store_ev));
    end
    res.total_hits      = hit_cnt;
    res.total_misses    = miss_cnt;
    res.total_evictions = evict_cnt;
    return res;
  endfunction

  // Idle length: mostly none or short, a few long
  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("ERROR @%0t result %0d: %s", $realtime, results_seen, msg);
    mismatch_count++;
  endtask

  task automatic check_result();
    access_result_t want;
    if (pending_results.size() == 0) begin
      flag_mismatch("result transfer with no access outstanding");
      return;
    end
    want = pending_results.pop_front();
    if (rsp_if.first_hit !== want.first_hit)
      flag_mismatch($sformatf("first_hit %0b, expected %0b", rsp_if.first_hit, want.first_hit));
    if (rsp_if.evicted !== want.evicted)
      flag_mismatch($sformatf("evicted %0b, expected %0b", rsp_if.evicted, want.evicted));
    if (rsp_if.was_ignored !== want.was_ignored)
      flag_mismatch($sformatf("was_ignored %0b, expected %0b",
                              rsp_if.was_ignored, want.was_ignored));
    if (rsp_if.total_hits !== want.total_hits)
      flag_mismatch($sformatf("total_hits %0d, expected %0d",
                              rsp_if.total_hits, want.total_hits));
    if (rsp_if.total_misses !== want.total_misses)
      flag_mismatch($sformatf("total_misses %0d, expected %0d",
                              rsp_if.total_misses, want.total_misses));
    if (rsp_if.total_evictions !== want.total_evictions)
      flag_mismatch($sformatf("total_evictions %0d, expected %0d",
                              rsp_if.total_evictions, want.total_evictions));
  endtask

  // Result side: check each transfer, then pick ready for the next edge
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      check_result();
      results_seen++;
    end
    if (stall_left != 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      stall_left = pick_gap(recv_calm);
      rsp_if.ready <= (stall_left == 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("set_assoc_lru_cache_sim_unit verification failed");
      $finish;
    end
  end

  // Offer one access, wait for its transfer, record the expected result
  task automatic send_access(input cmd_e cmd, input logic [ADDR_W-1:0] addr);
    int unsigned gap;
    gap = pick_gap(send_calm);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid   <= 1'b1;
    req_if.command <= cmd;
    req_if.address <= addr;
    do @(posedge clk_i); while (!req_if.ready);
    pending_results.push_back(predict_access(cmd, addr));
  endtask

  // Drop valid, wait for every outstanding result, then let the pipe empty
  task automatic settle();
    req_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SET_BITS:   cfg_set_bits   = val[2:0];
      CFG_BLOCK_BITS: cfg_block_bits = val[4:0];
      CFG_WAYS:       cfg_ways       = val[3:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic set_geometry(input logic [2:0] sb, input logic [4:0] bb, input logic [3:0] ways);
    settle();
    write_reg(CFG_SET_BITS, CFG_DATA_W'(sb));
    write_reg(CFG_BLOCK_BITS, bb);
    write_reg(CFG_WAYS, CFG_DATA_W'(ways));
  endtask

  // Reset geometry: 16 sets, 16-byte blocks, direct mapped
  task automatic test_default_geometry();
    send_access(CMD_LOAD, 32'h0000_0000);
    send_access(CMD_LOAD, 32'h0000_000F);
    send_access(CMD_STORE, 32'hFFFF_FFFF);
    send_access(CMD_LOAD, 32'h0000_0100);
    send_access(CMD_MODIFY, 32'h0000_0000);
    send_access(CMD_IFETCH, 32'hA5A5_A5A5);
    send_access(CMD_MODIFY, 32'h0000_0000);
    send_access(CMD_STORE, 32'h0000_0100);
  endtask

  // Clamped set bits, tag-free wide shift, out-of-range way counts, unused index
  task automatic test_register_extremes();
    set_geometry(3'd7, 5'd31, 4'd15);
    send_access(CMD_LOAD, 32'h8000_0000);
    send_access(CMD_LOAD, 32'h0000_0000);
    send_access(CMD_STORE, 32'hFFFF_FFFF);
    set_geometry(3'd0, 5'd0, 4'd0);
    send_access(CMD_LOAD, 32'h0000_0001);
    send_access(CMD_LOAD, 32'h0000_0001);
    send_access(CMD_MODIFY, 32'hFFFF_FFFF);
    send_access(CMD_IFETCH, 32'h0000_0000);
    settle();
    write_reg(CFG_UNUSED, 5'h1F);
    send_access(CMD_LOAD, 32'hFFFF_FFFF);
  endtask

  // Shrink and regrow the way count so a set holds the same tag twice
  // and ranks tie
  task automatic test_duplicate_ways();
    set_geometry(3'd0, 5'd0, 4'd2);
    send_access(CMD_LOAD, 32'h0000_0010);
    send_access(CMD_LOAD, 32'h0000_0020);
    set_geometry(3'd0, 5'd0, 4'd1);
    send_access(CMD_LOAD, 32'h0000_0020);
    set_geometry(3'd0, 5'd0, 4'd2);
    send_access(CMD_LOAD, 32'h0000_0020);
    send_access(CMD_LOAD, 32'h0000_0030);
    set_geometry(3'd0, 5'd0, 4'd8);
    send_access(CMD_STORE, 32'h0000_0040);
    send_access(CMD_LOAD, 32'h0000_0010);
  endtask

  // Random traffic over several geometries; most addresses collide in a
  // few sets with a handful of tags so hits and evictions are frequent
  task automatic test_random_traffic();
    logic [2:0] sb_tab [6] = '{3'd4, 3'd2, 3'd6, 3'd7, 3'd0, 3'd3};
    logic [4:0] bb_tab [6] = '{5'd4, 5'd3, 5'd26, 5'd31, 5'd0, 5'd5};
    logic [3:0] wy_tab [6] = '{4'd1, 4'd4, 4'd8, 4'd15, 4'd0, 4'd3};
    int unsigned sb_eff;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] tag_part;
    logic [ADDR_W-1:0] set_part;
    cmd_e cmd;
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph < 6)
        set_geometry(sb_tab[ph], bb_tab[ph], wy_tab[ph]);
      else
        set_geometry(3'($urandom_range(0, 7)), 5'($urandom_range(0, 31)),
                     4'($urandom_range(0, 15)));
      sb_eff    = eff_set_bits();
      send_calm = (ph == 1) || (ph == 4);
      recv_calm = (ph == 1);
      repeat (ITEMS_PER_PHASE) begin
        if ($urandom_range(99) < 8) cmd = CMD_IFETCH;
        else cmd = cmd_e'($urandom_range(0, 2));
        addr = $urandom;
        if ($urandom_range(99) < 80) begin
          tag_part = $urandom_range(0, 2 * eff_ways() + 1);
          set_part = $urandom_range(0, 3) & ((32'd1 << sb_eff) - 1);
          addr = (addr & ((32'd1 << cfg_block_bits) - 1)) | (set_part << cfg_block_bits) |
                 (tag_part << (sb_eff + cfg_block_bits));
        end
        send_access(cmd, addr);
      end
    end
    send_calm = 1'b0;
    recv_calm = 1'b0;
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_SET_BITS;
    cfg_wdata_i    = '0;
    req_if.valid   = 1'b0;
    req_if.command = CMD_LOAD;
    req_if.address = '0;
    rsp_if.ready   = 1'b0;
    mismatch_count = 0;
    results_seen   = 0;
    quiet_cycles   = 0;
    stall_left     = 0;
    send_calm      = 1'b0;
    recv_calm      = 1'b0;
    cfg_set_bits   = SET_BITS_RST;
    cfg_block_bits = BLOCK_BITS_RST;
    cfg_ways       = WAYS_RST;
    hit_cnt        = '0;
    miss_cnt       = '0;
    evict_cnt      = '0;
    for (int s = 0; s < NUM_SETS; s++) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        line_ok[s][w]   = 1'b0;
        line_tag[s][w]  = '0;
        line_rank[s][w] = 0;
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_geometry();
    test_register_extremes();
    test_duplicate_ways();
    test_random_traffic();
    settle();

    if (mismatch_count == 0) begin
      $display("set_assoc_lru_cache_sim_unit verification clean");
    end else begin
      $display("set_assoc_lru_cache_sim_unit verification failed");
    end
    $finish;
  end

endmodule
